[sv/usrs_pkg.sv]
package usrs_pkg;

  localparam int DEFAULT_CAPACITY      = 16;
  localparam int DEFAULT_SNAPSHOT_BITS = 64;
  localparam int SNAP_FIELD_BITS       = 64;
  localparam int DEPTH_FIELD_BITS      = 5;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_UNDO  = 2'd1;
  localparam logic [1:0] KIND_REDO  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [SNAP_FIELD_BITS-1:0] snapshot;
  } usrs_in_t;

  typedef struct packed {
    logic [SNAP_FIELD_BITS-1:0]  restored;
    logic                        done_res;
    logic [DEPTH_FIELD_BITS-1:0] undo_depth;
    logic [DEPTH_FIELD_BITS-1:0] redo_depth;
  } usrs_out_t;

  // Shift command shared by every cell of a chain.
  typedef struct packed {
    logic push;
    logic pop;
  } usrs_shift_t;

endpackage

[sv/usrs_cell.sv]
module usrs_cell import usrs_pkg::*; #(
  parameter int W = DEFAULT_SNAPSHOT_BITS
) (
  input  logic         clk,
  input  usrs_shift_t  ctrl,
  input  logic [W-1:0] from_prev,
  input  logic [W-1:0] from_next,
  output logic [W-1:0] value
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      value <= from_prev;
    end else if (ctrl.pop) begin
      value <= from_next;
    end
  end

endmodule

[sv/usrs_chain.sv]
module usrs_chain import usrs_pkg::*; #(
  parameter int DEPTH = DEFAULT_CAPACITY,
  parameter int W     = DEFAULT_SNAPSHOT_BITS
) (
  input  logic         clk,
  input  usrs_shift_t  ctrl,
  input  logic [W-1:0] din,
  output logic [W-1:0] top_value
);

  logic [W-1:0] links [DEPTH];

  // Cell 0 is the newest entry. A push moves every entry one cell deeper and
  // drops the deepest one; a pop moves every entry one cell toward the top.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] prev_value;
    logic [W-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_value = din;
    end else begin : g_inner
      assign prev_value = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_value = links[i];
    end else begin : g_mid
      assign next_value = links[i+1];
    end

    usrs_cell #(.W(W)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_prev (prev_value),
      .from_next (next_value),
      .value     (links[i])
    );
  end

  assign top_value = links[0];

endmodule

[sv/undo_redo_snapshot_stack.sv]
// Bounded undo/redo snapshot history.
// Input channel (in_valid, in_stall, in_item) carries one operation per
// transaction: push, undo, redo or clear, plus the current snapshot word.
// Output channel (out_valid, out_stall, out_item) returns one result per
// transaction: the restored snapshot, a done flag and both stack depths.
// Both stores are rows of CAPACITY cells that shift by one place per
// operation, so the newest entry always sits in the first cell and is read
// there directly.
// out_valid rises in the cycle after acceptance. A new transaction is
// taken every cycle as long as the output register is empty or being
// emptied, so throughput is one item per cycle, set by the single output
// register.
// A synchronous reset empties both stores (fill counts to zero) and drops
// any pending result; the cell contents are not cleared.
// While the receiver stalls, the result holds in the output register and
// in_stall is raised until it is taken.
module undo_redo_snapshot_stack import usrs_pkg::*; #(
  parameter int CAPACITY      = DEFAULT_CAPACITY,
  parameter int SNAPSHOT_BITS = DEFAULT_SNAPSHOT_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  usrs_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output usrs_out_t out_item
);

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

  logic [FILL_W-1:0] undo_fill, undo_fill_next;
  logic [FILL_W-1:0] redo_fill, redo_fill_next;

  logic                     accept;
  logic [SNAPSHOT_BITS-1:0] snap;
  logic [SNAPSHOT_BITS-1:0] undo_newest, redo_newest;
  logic [SNAPSHOT_BITS-1:0] result;
  logic                     done;
  usrs_shift_t              undo_ctrl, redo_ctrl;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign snap     = in_item.snapshot[SNAPSHOT_BITS-1:0];

  usrs_chain #(.DEPTH(CAPACITY), .W(SNAPSHOT_BITS)) u_undo (
    .clk       (clk),
    .ctrl      (undo_ctrl),
    .din       (snap),
    .top_value (undo_newest)
  );

  usrs_chain #(.DEPTH(CAPACITY), .W(SNAPSHOT_BITS)) u_redo (
    .clk       (clk),
    .ctrl      (redo_ctrl),
    .din       (snap),
    .top_value (redo_newest)
  );

  always_comb begin
    undo_ctrl      = '0;
    redo_ctrl      = '0;
    undo_fill_next = undo_fill;
    redo_fill_next = redo_fill;
    result         = snap;
    done           = 1'b1;
    unique case (in_item.kind)
      KIND_PUSH: begin
        undo_ctrl.push = accept;
        redo_fill_next = '0;
        if (undo_fill != FILL_MAX) begin
          undo_fill_next = undo_fill + 1'b1;
        end
      end
      KIND_UNDO: begin
        if (undo_fill == '0) begin
          done = 1'b0;
        end else begin
          undo_ctrl.pop  = accept;
          redo_ctrl.push = accept;
          result         = undo_newest;
          undo_fill_next = undo_fill - 1'b1;
          if (redo_fill != FILL_MAX) begin
            redo_fill_next = redo_fill + 1'b1;
          end
        end
      end
      KIND_REDO: begin
        if (redo_fill == '0) begin
          done = 1'b0;
        end else begin
          undo_ctrl.push = accept;
          redo_ctrl.pop  = accept;
          result         = redo_newest;
          redo_fill_next = redo_fill - 1'b1;
          if (undo_fill != FILL_MAX) begin
            undo_fill_next = undo_fill + 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        undo_fill_next = '0;
        redo_fill_next = '0;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      undo_fill <= '0;
      redo_fill <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        undo_fill <= undo_fill_next;
        redo_fill <= redo_fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.restored   <= SNAP_FIELD_BITS'(result);
      out_item.done_res   <= done;
      out_item.undo_depth <= DEPTH_FIELD_BITS'(undo_fill_next);
      out_item.redo_depth <= DEPTH_FIELD_BITS'(redo_fill_next);
    end
  end

  // The two stores together never hold more entries than one store has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, undo_fill} + {1'b0, redo_fill}) <= (FILL_W + 1)'(CAPACITY))
    else $error("undo and redo fill counts exceed capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_push_drops_redo: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.kind == KIND_PUSH |=> redo_fill == '0)
    else $error("push left entries on the redo stack");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.kind == KIND_CLEAR |=> undo_fill == '0 && redo_fill == '0)
    else $error("clear left entries in a store");

  a_no_shift_clash: assert property (@(posedge clk) disable iff (rst)
    !(undo_ctrl.push && undo_ctrl.pop) && !(redo_ctrl.push && redo_ctrl.pop))
    else $error("a chain was told to push and pop at once");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import usrs_pkg::*;

  localparam int CAPACITY     = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    usrs_in_t  item;
    bit        has_fixed;
    usrs_out_t fixed;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  usrs_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  usrs_out_t out_item;

  // Shadow copy of the history, updated once per accepted transaction.
  logic [SNAP_FIELD_BITS-1:0] undo_mem [CAPACITY];
  logic [SNAP_FIELD_BITS-1:0] redo_mem [CAPACITY];
  int unsigned                undo_slot;
  int unsigned                undo_entries;
  int unsigned                redo_count;

  usrs_out_t   expected_results [$];
  stim_row_t   directed_rows [$];
  int unsigned error_count;
  int unsigned result_count;
  int unsigned sent_count;
  int unsigned cycle_count;
  int unsigned overwrite_count;
  int unsigned refused_count;
  int unsigned redo_peak;
  bit          idle_on;
  bit          hold_off_req;

  always #1 clk = ~clk;

  undo_redo_snapshot_stack dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void save_undo(input logic [SNAP_FIELD_BITS-1:0] snap);
    if (undo_entries == CAPACITY) overwrite_count++;
    undo_mem[undo_slot] = snap;
    undo_slot = (undo_slot + 1) % CAPACITY;
    if (undo_entries < CAPACITY) undo_entries++;
  endfunction

  function automatic usrs_out_t history_step(input usrs_in_t op);
    usrs_out_t   r;
    int unsigned slot;
    r.restored = op.snapshot;
    r.done_res = 1'b1;
    case (op.kind)
      KIND_PUSH: begin
        save_undo(op.snapshot);
        redo_count = 0;
      end
      KIND_UNDO: begin
        if (undo_entries == 0) begin
          r.done_res = 1'b0;
        end else begin
          slot = (redo_count < CAPACITY) ? redo_count : CAPACITY - 1;
          redo_mem[slot] = op.snapshot;
          if (redo_count < CAPACITY) redo_count++;
          undo_slot = (undo_slot + CAPACITY - 1) % CAPACITY;
          r.restored = undo_mem[undo_slot];
          undo_entries--;
        end
      end
      KIND_REDO: begin
        if (redo_count == 0) begin
          r.done_res = 1'b0;
        end else begin
          save_undo(op.snapshot);
          redo_count--;
          r.restored = redo_mem[redo_count];
        end
      end
      default: begin
        undo_slot    = 0;
        undo_entries = 0;
        redo_count   = 0;
      end
    endcase
    if (!r.done_res) refused_count++;
    if (redo_count > redo_peak) redo_peak = redo_count;
    r.undo_depth = undo_entries[DEPTH_FIELD_BITS-1:0];
    r.redo_depth = redo_count[DEPTH_FIELD_BITS-1:0];
    return r;
  endfunction

  function automatic stim_row_t make_row(input logic [1:0] kind,
                                         input logic [SNAP_FIELD_BITS-1:0] snap,
                                         input bit has_fixed,
                                         input logic [SNAP_FIELD_BITS-1:0] restored,
                                         input logic done_res,
                                         input int unsigned undo_d,
                                         input int unsigned redo_d);
    stim_row_t row;
    row.item.kind         = kind;
    row.item.snapshot     = snap;
    row.has_fixed         = has_fixed;
    row.fixed.restored    = restored;
    row.fixed.done_res    = done_res;
    row.fixed.undo_depth  = undo_d[DEPTH_FIELD_BITS-1:0];
    row.fixed.redo_depth  = redo_d[DEPTH_FIELD_BITS-1:0];
    return row;
  endfunction

  // Offers one transaction and records its expectation once it is taken.
  task automatic send_item(input usrs_in_t item, input bit has_fixed,
                           input usrs_out_t fixed);
    usrs_out_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    predicted = history_step(item);
    expected_results.push_back(has_fixed ? fixed : predicted);
    sent_count++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    usrs_out_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no transaction pending");
      end else begin
        want = expected_results.pop_front();
        if (out_item.restored !== want.restored)
          report_mismatch($sformatf("restored %h, expected %h",
                                    out_item.restored, want.restored));
        if (out_item.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, expected %b",
                                    out_item.done_res, want.done_res));
        if (out_item.undo_depth !== want.undo_depth)
          report_mismatch($sformatf("undo_depth %0d, expected %0d",
                                    out_item.undo_depth, want.undo_depth));
        if (out_item.redo_depth !== want.redo_depth)
          report_mismatch($sformatf("redo_depth %0d, expected %0d",
                                    out_item.redo_depth, want.redo_depth));
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    usrs_in_t                   item;
    logic [SNAP_FIELD_BITS-1:0] snap;
    logic [1:0]                 kind;
    int unsigned                pick;
    int unsigned                burst;
    int unsigned                n;

    undo_slot       = 0;
    undo_entries    = 0;
    redo_count      = 0;
    redo_peak       = 0;
    error_count     = 0;
    result_count    = 0;
    sent_count      = 0;
    cycle_count     = 0;
    overwrite_count = 0;
    refused_count   = 0;
    idle_on         = 1'b1;
    hold_off_req    = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      undo_mem[i] = '0;
      redo_mem[i] = '0;
    end

    // Empty-stack refusals and a clear on an empty history.
    directed_rows.push_back(make_row(KIND_UNDO, '1, 1, '1, 1'b0, 0, 0));
    directed_rows.push_back(make_row(KIND_REDO, '0, 1, '0, 1'b0, 0, 0));
    directed_rows.push_back(make_row(KIND_CLEAR, 64'h8000_0000_0000_0001, 1,
                                     64'h8000_0000_0000_0001, 1'b1, 0, 0));
    // Pushes past capacity so that the oldest entries are overwritten.
    for (int i = 0; i < CAPACITY + 2; i++) begin
      case (i)
        0:       snap = '0;
        1:       snap = '1;
        2:       snap = 64'h8000_0000_0000_0000;
        default: snap = {$urandom, $urandom};
      endcase
      directed_rows.push_back(make_row(KIND_PUSH, snap, 1, snap, 1'b1,
                                       (i + 1 < CAPACITY) ? i + 1 : CAPACITY, 0));
    end
    directed_rows.push_back(make_row(KIND_UNDO, 64'h5555_5555_5555_5555, 0, '0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_REDO, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, 0, 0, 0));
    directed_rows.push_back(make_row(KIND_CLEAR, 64'h1234, 1, 64'h1234, 1'b1, 0, 0));
    directed_rows.push_back(make_row(KIND_UNDO, 64'h4321, 1, 64'h4321, 1'b0, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].has_fixed, directed_rows[i].fixed);

    // Random part: runs of one operation drive the stores to both full and empty.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 38)      kind = KIND_PUSH;
      else if (pick < 68) kind = KIND_UNDO;
      else if (pick < 96) kind = KIND_REDO;
      else                kind = KIND_CLEAR;
      burst = (kind == KIND_CLEAR) ? 1 : $urandom_range(1, 20);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
        case ($urandom_range(0, 15))
          0:       snap = '0;
          1:       snap = '1;
          default: snap = {$urandom, $urandom};
        endcase
        item.kind     = kind;
        item.snapshot = snap;
        if (n == RANDOM_ITEMS / 3) hold_off_req = 1'b1;
        if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
        send_item(item, 1'b0, '0);
        n++;
      end
    end
    in_valid <= 1'b0;

    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Sent %0d transactions and checked %0d results; %0d undo/redo were refused.",
             sent_count, result_count, refused_count);
    $display("Full undo store overwritten %0d times; deepest redo stack %0d.",
             overwrite_count, redo_peak);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
